// ===== sv/vprc_pkg.sv =====
// Package for the vector plane rotation chain.
// Shared widths, plane codes, register indexes and the sine/cosine step functions.
// No dependencies.
package vprc_pkg;

  localparam int unsigned MAX_ROTATIONS = 4;
  localparam int unsigned CompW = 16;
  localparam int unsigned RegW  = 18;
  localparam int unsigned CntW  = 3;
  localparam int unsigned IdxW  = 3;

  localparam logic [1:0] PLANE_YX = 2'd0;
  localparam logic [1:0] PLANE_YZ = 2'd1;

  localparam logic [IdxW-1:0] REG_COUNT = 3'd0;
  localparam logic [IdxW-1:0] REG_ROT0  = 3'd1;

  // Cycles the input stays blocked after a register write while the trig pipe refills.
  localparam logic [1:0] TRIG_SETTLE = 2'd3;

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    logic [1:0]   plane;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } trig_t;

  // Quarter sine, Q14 in, Q14 out, r in 0..16384, split into one multiply per step.
  function automatic logic [15:0] sine_sq(input logic [14:0] r);
    logic [29:0] rr;
    rr = 30'(r) * 30'(r);
    return rr[29:14];
  endfunction

  function automatic logic [13:0] sine_t(input logic [15:0] x2);
    logic [27:0] p1;
    p1 = 28'(x2) * 28'd1160;
    return 14'(14'd10512 - 14'(p1[27:14]));
  endfunction

  function automatic logic [15:0] sine_u(input logic [15:0] x2, input logic [13:0] t);
    logic [29:0] p2;
    p2 = 30'(x2) * 30'(t);
    return 16'(16'd25736 - 16'(p2[29:14]));
  endfunction

  function automatic logic [15:0] sine_out(input logic [14:0] r, input logic [15:0] u);
    logic [30:0] p3;
    p3 = 31'(r) * 31'(u);
    return p3[29:14];
  endfunction

endpackage

// ===== sv/vprc_stage.sv =====
// One rotation stage of the chain: multiply, then round and saturate.
// Depends on vprc_pkg.
module vprc_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic                 enable,
  input  vprc_pkg::trig_t      trig,
  input  vprc_pkg::comp_t      in_x,
  input  vprc_pkg::comp_t      in_y,
  input  vprc_pkg::comp_t      in_z,
  output logic                 out_valid,
  output vprc_pkg::comp_t      out_x,
  output vprc_pkg::comp_t      out_y,
  output vprc_pkg::comp_t      out_z
);
  import vprc_pkg::*;

  // product register
  logic               mvalid;
  logic               men;
  logic [1:0]         mplane;
  logic signed [31:0] pac, pbs, pas, pbc;
  comp_t              mx, my, mz;

  comp_t a, b;
  always_comb begin
    case (trig.plane)
      PLANE_YX: begin a = in_x; b = in_y; end
      PLANE_YZ: begin a = in_z; b = in_y; end
      default:  begin a = in_x; b = in_z; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      mvalid <= in_valid;
      out_valid <= mvalid;
    end
    if (adv) begin
      men <= enable;
      mplane <= trig.plane;
      pac <= 32'(a * trig.cs);
      pbs <= 32'(b * trig.sn);
      pas <= 32'(a * trig.sn);
      pbc <= 32'(b * trig.cs);
      mx <= in_x; my <= in_y; mz <= in_z;
    end
  end

  function automatic comp_t rnd(input logic signed [32:0] v);
    logic signed [32:0] w;
    logic signed [18:0] q;
    w = v + 33'sd8192;
    q = w[32:14];
    if (q > 19'sd32767)       return 16'sh7fff;
    else if (q < -19'sd32768) return 16'sh8000;
    else                      return q[15:0];
  endfunction

  comp_t np, nq;
  assign np = rnd(33'(pac) + 33'(pbs));
  assign nq = rnd(33'(pbc) - 33'(pas));

  // Pass the vector through, replacing the rotated pair when enabled.
  comp_t x_next, y_next, z_next;
  always_comb begin
    x_next = mx;
    y_next = my;
    z_next = mz;
    if (men) begin
      case (mplane)
        PLANE_YX: begin x_next = np; y_next = nq; end
        PLANE_YZ: begin z_next = np; y_next = nq; end
        default:  begin x_next = np; z_next = nq; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= x_next; out_y <= y_next; out_z <= z_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) adv |=> out_valid == $past(mvalid))
    else $error("stage valid lost");
  assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(out_x) && $stable(out_valid))
    else $error("stage moved while stalled");
  assert property (@(posedge clk) disable iff (rst)
    adv && !enable |=> mx == $past(in_x) && !men)
    else $error("bypass corrupted");
endmodule

// ===== sv/vector_plane_rotation_chain_top.sv =====
// Top level of the vector plane rotation chain.
// Depends on vprc_pkg and vprc_stage.
//
// Usage:
//   Input channel in_valid/in_ready carries one direction word (dir_x,
//   dir_y, dir_z, signed Q1.14). Output channel out_valid/out_ready
//   carries the rotated word (rot_x, rot_y, rot_z), saturated Q1.14.
//   Configuration: cfg_we, cfg_index, cfg_data. Index 0 is the rotation
//   count, 1..4 the rotations (plane in bits 17:16, angle in 15:0).
//   Write configuration only while the pipe is empty.
// Path: a word passes the entry register, then two register stages per
//   rotation (products, then round/saturate) before out_valid rises.
//   Throughput: one word per cycle; the pipeline takes a new word in every
//   cycle while the output is taken and no write or trig refill holds in_ready.
// Reset: count and rotations clear to 0, all valid bits clear.
// Stall: when out_ready is low with a word waiting, the whole pipe holds;
//   in_ready drops and nothing is lost or repeated.
// Sine and cosine are computed from the registers in a four-stage trig pipe,
//   one multiply per stage; in_ready stays low during a write and after it
//   (and after reset) while that pipe refills, until the settle counter is zero.
module vector_plane_rotation_chain_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vprc_pkg::comp_t        dir_x,
  input  vprc_pkg::comp_t        dir_y,
  input  vprc_pkg::comp_t        dir_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vprc_pkg::comp_t        rot_x,
  output vprc_pkg::comp_t        rot_y,
  output vprc_pkg::comp_t        rot_z,
  input  logic                   cfg_we,
  input  logic [vprc_pkg::IdxW-1:0] cfg_index,
  input  logic [vprc_pkg::RegW-1:0] cfg_data
);
  import vprc_pkg::*;

  logic [CntW-1:0] rotation_count;
  logic [RegW-1:0] rotation [MAX_ROTATIONS];
  trig_t           trig [MAX_ROTATIONS];

  // Advance the whole pipe unless the output word is stalled.
  logic adv;
  logic [1:0] settle;
  assign adv = !out_valid || out_ready;
  // Hold off new words while a write is in progress or the trig pipe refills.
  assign in_ready = adv && !cfg_we && (settle == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_count <= '0;
      for (int i = 0; i < MAX_ROTATIONS; i++) rotation[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_COUNT) rotation_count <= cfg_data[CntW-1:0];
      else if (cfg_index >= REG_ROT0 && cfg_index <= IdxW'(MAX_ROTATIONS))
        rotation[2'(cfg_index - REG_ROT0)] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) settle <= TRIG_SETTLE;
    else if (cfg_we) settle <= TRIG_SETTLE;
    else if (settle != 2'd0) settle <= settle - 2'd1;
  end

  // Trig pipe: square, then t, then u, then the sines and the quadrant fold.
  // The registers are stable once settled, so later steps read them directly.
  for (genvar g = 0; g < MAX_ROTATIONS; g++) begin : g_trig
    logic [14:0] ra, rb;
    logic [15:0] xa, xb;
    logic [13:0] t_a, t_b;
    logic [15:0] u_a, u_b;
    logic [15:0] sa, sb;
    assign ra = {1'b0, rotation[g][13:0]};
    assign rb = 15'd16384 - ra;
    always_ff @(posedge clk) begin
      xa  <= sine_sq(ra);
      xb  <= sine_sq(rb);
      t_a <= sine_t(xa);
      t_b <= sine_t(xb);
      u_a <= sine_u(xa, t_a);
      u_b <= sine_u(xb, t_b);
    end
    assign sa = sine_out(ra, u_a);
    assign sb = sine_out(rb, u_b);
    always_ff @(posedge clk) begin
      trig[g].plane <= rotation[g][17:16];
      case (rotation[g][15:14])
        2'd0:    begin trig[g].sn <= sa;  trig[g].cs <= sb;  end
        2'd1:    begin trig[g].sn <= sb;  trig[g].cs <= -sa; end
        2'd2:    begin trig[g].sn <= -sa; trig[g].cs <= -sb; end
        default: begin trig[g].sn <= -sb; trig[g].cs <= sa;  end
      endcase
    end
  end

  // Entry register.
  logic  v0;
  comp_t x0, y0, z0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_valid && in_ready;
    if (adv) begin
      x0 <= dir_x; y0 <= dir_y; z0 <= dir_z;
    end
  end

  logic  sv [MAX_ROTATIONS+1];
  comp_t sx [MAX_ROTATIONS+1];
  comp_t sy [MAX_ROTATIONS+1];
  comp_t sz [MAX_ROTATIONS+1];
  assign sv[0] = v0;
  assign sx[0] = x0;
  assign sy[0] = y0;
  assign sz[0] = z0;

  for (genvar g = 0; g < MAX_ROTATIONS; g++) begin : g_rot
    logic en;
    assign en = rotation_count > CntW'(g);
    vprc_stage u_stage (
      .clk, .rst, .adv,
      .in_valid (sv[g]),
      .enable   (en),
      .trig     (trig[g]),
      .in_x     (sx[g]), .in_y (sy[g]), .in_z (sz[g]),
      .out_valid(sv[g+1]),
      .out_x    (sx[g+1]), .out_y (sy[g+1]), .out_z (sz[g+1])
    );
  end

  assign out_valid = sv[MAX_ROTATIONS];
  assign rot_x = sx[MAX_ROTATIONS];
  assign rot_y = sy[MAX_ROTATIONS];
  assign rot_z = sz[MAX_ROTATIONS];

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |-> !in_ready)
    else $error("accepted while stalled");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y))
    else $error("output changed while stalled");
  assert property (@(posedge clk) disable iff (rst) rotation_count == 0 && adv |=> x0 == $past(dir_x))
    else $error("entry register lost word");
endmodule
